// ----- sv/pate_pkg.sv -----
// Package for the positional array table engine.
// Holds the beat structs, operation codes and status codes. No dependencies.
`timescale 1ns / 1ps
package pate_pkg;

  // Operation codes
  localparam logic [3:0] OP_INSERT = 4'd0;
  localparam logic [3:0] OP_DELPOS = 4'd1;
  localparam logic [3:0] OP_DELVAL = 4'd2;
  localparam logic [3:0] OP_SEARCH = 4'd3;
  localparam logic [3:0] OP_GET    = 4'd4;
  localparam logic [3:0] OP_UPDATE = 4'd5;
  localparam logic [3:0] OP_REV    = 4'd6;
  localparam logic [3:0] OP_SORT   = 4'd7;
  localparam logic [3:0] OP_DEDUP  = 4'd8;
  localparam logic [3:0] OP_ROTL   = 4'd9;
  localparam logic [3:0] OP_ROTR   = 4'd10;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [3:0]         op;
    logic signed [31:0] data_value;
    logic [10:0]        position;
    logic [15:0]        rotate_amount;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] result_value;
    logic [9:0]         found_index;
    logic [10:0]        count_after;
  } rsp_t;

endpackage

// ----- sv/pate_mem.sv -----
// Entry store of the positional array table engine: one write port and
// one read port, read data registered. Depends on nothing.
`timescale 1ns / 1ps
module pate_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [31:0]       wdata,
  input  logic [AW-1:0]     raddr,
  output logic [31:0]       rdata
);

  logic [31:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/pate_mod.sv -----
// Modulo unit: reduces the rotate amount modulo the count, one quotient
// bit a cycle by restoring subtraction. Depends on nothing.
`timescale 1ns / 1ps
module pate_mod #(
  parameter int CW = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  logic [15:0]   dividend,
  input  logic [CW-1:0] divisor,
  output logic          done,
  output logic [CW-1:0] remainder
);

  logic [15:0] quo;
  logic [CW:0] rem;
  logic [4:0]  cnt;
  logic        run;
  logic [CW:0] trial;

  assign trial     = {rem[CW-1:0], quo[15]};
  assign remainder = rem[CW-1:0];

  // Shift one dividend bit into the partial remainder a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        quo <= dividend;
        rem <= '0;
        cnt <= 5'd16;
      end else if (run) begin
        quo <= {quo[14:0], 1'b0};
        if (trial >= {1'b0, divisor}) begin
          rem <= trial - {1'b0, divisor};
        end else begin
          rem <= trial;
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- sv/positional_array_table_engine_top.sv -----
// Top level of the positional array table engine: the sequencer that walks
// the entry store. Depends on pate_pkg, pate_mem and pate_mod.
`timescale 1ns / 1ps
// Usage:
//   A command beat (cmd) is taken at a clock edge where start is high and
//   busy is low. Exactly one response beat (rsp) follows, marked by done for
//   one cycle; the receiver cannot stall it. busy falls as done rises, so the
//   next command can be taken at the edge that ends the response beat.
//   One command is worked at a time. The entries live in one memory with one
//   write port and one registered read port, and the sequencer walks it one
//   entry a cycle in shifts, searches and dedupe. Error cases, short lists
//   and unused codes go straight to the response. Rotate first reduces the
//   amount modulo the count, then runs three reversals; dedupe sorts the
//   entries first and then compacts them.
//   Reset clears the count to zero and the control to idle; the entry store
//   is not cleared, as no entry is read before it has been written.
module positional_array_table_engine_top #(
  parameter int CAPACITY = 1024
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  pate_pkg::cmd_t cmd,
  output logic           busy,
  output logic           done,
  output pate_pkg::rsp_t rsp
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 11) ? CW : 11;

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_GET   = 4'd1;   // data of the position back
  localparam logic [3:0] S_SHUP  = 4'd2;   // insert shift step
  localparam logic [3:0] S_SHDN  = 4'd3;   // delete shift step
  localparam logic [3:0] S_SCAN  = 4'd4;   // search step
  localparam logic [3:0] S_MOD   = 4'd5;
  localparam logic [3:0] S_SPAN  = 4'd6;   // start of a reversal span
  localparam logic [3:0] S_RDA   = 4'd7;   // read at ia issued
  localparam logic [3:0] S_RDB   = 4'd8;   // data of ia back, read ib issued
  localparam logic [3:0] S_SWAP  = 4'd9;   // data of ib back, write first half
  localparam logic [3:0] S_WB    = 4'd10;  // write second half, advance
  localparam logic [3:0] S_NEXT  = 4'd11;  // end of a reversal span
  localparam logic [3:0] S_DDB   = 4'd12;  // entry 0 back for dedupe
  localparam logic [3:0] S_DEDUP = 4'd13;
  localparam logic [3:0] S_FIN   = 4'd14;

  // Span mode for pair walks
  localparam logic [1:0] M_REV  = 2'd0;
  localparam logic [1:0] M_SORT = 2'd1;

  logic [3:0]     state;
  pate_pkg::cmd_t c;
  logic [CW-1:0]  count;
  logic [1:0]     status;
  logic [31:0]    rval;
  logic [AW-1:0]  fidx;
  logic [CW-1:0]  ia, ib, lim;   // walk indices and sort pass limit
  logic [31:0]    va;
  logic [1:0]     mode;
  logic [1:0]     phase;         // rotation reversal phase
  logic [CW-1:0]  rk;
  logic [CW-1:0]  wr;            // dedupe write index
  logic [31:0]    last;
  logic           swapped;
  logic           pend;          // second half of a swap still to write

  logic           we;
  logic [AW-1:0]  waddr, raddr;
  logic [31:0]    wdata, rdata;
  logic           mod_go, mod_done;
  logic [CW-1:0]  mod_rem;
  logic           swap_now;
  logic           keep_now;
  logic [CW-1:0]  rot_k;

  pate_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  pate_mod #(.CW(CW)) u_mod (
    .clk(clk), .rst(rst), .go(mod_go), .dividend(c.rotate_amount),
    .divisor(count), .done(mod_done), .remainder(mod_rem)
  );

  assign busy     = (state != S_IDLE);
  assign swap_now = (mode == M_REV) || ($signed(va) > $signed(rdata));
  assign keep_now = (rdata != last);
  assign rot_k    = (c.op == pate_pkg::OP_ROTR) ? count - mod_rem : mod_rem;

  // Memory port control: a read issued in one state returns in the next.
  always_comb begin
    raddr = AW'(ia);
    we    = 1'b0;
    waddr = AW'(ia);
    wdata = rdata;
    case (state)
      S_IDLE: begin
        case (cmd.op)
          pate_pkg::OP_INSERT: raddr = AW'(count - CW'(1));
          pate_pkg::OP_DELPOS, pate_pkg::OP_GET, pate_pkg::OP_UPDATE:
            raddr = AW'(cmd.position);
          default: raddr = '0;
        endcase
      end
      S_GET: begin
        raddr = AW'(ia + CW'(1));
        we    = (c.op == pate_pkg::OP_UPDATE);
        wdata = c.data_value;
      end
      S_SHUP: begin
        raddr = AW'(ia - CW'(2));
        we    = 1'b1;
        if (ia == CW'(c.position)) begin
          wdata = c.data_value;
        end
      end
      S_SHDN: begin
        raddr = AW'(ia + CW'(2));
        we    = 1'b1;
      end
      S_SCAN: raddr = AW'(ia + CW'(1));
      S_RDB:  raddr = AW'(ib);
      S_SWAP: we = swap_now;
      S_WB: begin
        raddr = '0;
        we    = pend;
        waddr = AW'(ib);
        wdata = va;
      end
      S_DEDUP: begin
        raddr = AW'(ia + CW'(1));
        we    = keep_now;
        waddr = AW'(wr);
      end
      default: ;
    endcase
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      done   <= 1'b0;
      mod_go <= 1'b0;
    end else begin
      done   <= 1'b0;
      mod_go <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            c      <= cmd;
            status <= pate_pkg::ST_OK;
            rval   <= '0;
            fidx   <= '0;
            state  <= S_FIN;
            case (cmd.op)
              pate_pkg::OP_INSERT: begin
                if (PW'(cmd.position) > PW'(count)) begin
                  status <= pate_pkg::ST_RANGE;
                end else if (count >= CW'(CAPACITY)) begin
                  status <= pate_pkg::ST_FULL;
                end else begin
                  ia    <= count;
                  state <= S_SHUP;
                end
              end
              pate_pkg::OP_DELPOS, pate_pkg::OP_GET, pate_pkg::OP_UPDATE: begin
                if (PW'(cmd.position) >= PW'(count)) begin
                  status <= pate_pkg::ST_RANGE;
                end else begin
                  ia    <= CW'(cmd.position);
                  state <= S_GET;
                end
              end
              pate_pkg::OP_DELVAL, pate_pkg::OP_SEARCH: begin
                if (count == '0) begin
                  status <= (cmd.op == pate_pkg::OP_DELVAL) ?
                            pate_pkg::ST_RANGE : pate_pkg::ST_NOTFOUND;
                end else begin
                  ia    <= '0;
                  state <= S_SCAN;
                end
              end
              pate_pkg::OP_REV: begin
                if (count > CW'(1)) begin
                  mode  <= M_REV;
                  phase <= 2'd2;
                  ia    <= '0;
                  ib    <= count - CW'(1);
                  state <= S_SPAN;
                end
              end
              pate_pkg::OP_SORT, pate_pkg::OP_DEDUP: begin
                if (count > CW'(1)) begin
                  mode    <= M_SORT;
                  ia      <= '0;
                  ib      <= CW'(1);
                  lim     <= count - CW'(1);
                  swapped <= 1'b0;
                  state   <= S_RDA;
                end
              end
              pate_pkg::OP_ROTL, pate_pkg::OP_ROTR: begin
                if (count > CW'(1)) begin
                  mod_go <= 1'b1;
                  state  <= S_MOD;
                end
              end
              default: ;
            endcase
          end
        end

        // Rotation amount known: finish if it is zero, else start the first reversal over [0, k-1].
        S_MOD: begin
          if (mod_done) begin
            if (mod_rem == '0) begin
              state <= S_FIN;
            end else begin
              rk    <= rot_k;
              mode  <= M_REV;
              phase <= 2'd0;
              ia    <= '0;
              ib    <= rot_k - CW'(1);
              state <= S_SPAN;
            end
          end
        end

        S_GET: begin
          state <= S_FIN;
          rval  <= rdata;
          if (c.op == pate_pkg::OP_DELPOS) begin
            if (ia + CW'(1) < count) begin
              state <= S_SHDN;
            end else begin
              count <= count - CW'(1);
            end
          end
        end

        // Insert: move entry ia-1 to ia, down to the position.
        S_SHUP: begin
          if (ia == CW'(c.position)) begin
            count <= count + CW'(1);
            state <= S_FIN;
          end else begin
            ia <= ia - CW'(1);
          end
        end

        // Delete: rdata holds entry ia+1, which moves to ia.
        S_SHDN: begin
          ia <= ia + CW'(1);
          if (ia + CW'(2) >= count) begin
            count <= count - CW'(1);
            state <= S_FIN;
          end
        end

        // Linear search for the first match.
        S_SCAN: begin
          if (rdata == c.data_value) begin
            fidx <= AW'(ia);
            if (c.op == pate_pkg::OP_DELVAL) begin
              rval <= rdata;
              if (ia + CW'(1) < count) begin
                state <= S_SHDN;
              end else begin
                count <= count - CW'(1);
                state <= S_FIN;
              end
            end else begin
              state <= S_FIN;
            end
          end else if (ia + CW'(1) >= count) begin
            status <= pate_pkg::ST_NOTFOUND;
            state  <= S_FIN;
          end else begin
            ia <= ia + CW'(1);
          end
        end

        // An empty or single-entry span needs no swaps.
        S_SPAN: begin
          state <= (ia < ib) ? S_RDA : S_NEXT;
        end

        S_RDA: begin
          state <= S_RDB;
        end

        S_RDB: begin
          va    <= rdata;
          state <= S_SWAP;
        end

        // Pair step: swap for reversal, compare-and-swap for sorting.
        S_SWAP: begin
          pend <= swap_now;
          if (mode == M_SORT && swap_now) begin
            swapped <= 1'b1;
          end
          state <= S_WB;
        end

        // Second half of the swap is written; move to the next pair, start the next sort pass, or end the walk.
        S_WB: begin
          if (mode == M_REV) begin
            if (ia + CW'(1) < ib - CW'(1)) begin
              ia    <= ia + CW'(1);
              ib    <= ib - CW'(1);
              state <= S_RDA;
            end else begin
              state <= S_NEXT;
            end
          end else begin
            if (ib < lim) begin
              ia    <= ib;
              ib    <= ib + CW'(1);
              state <= S_RDA;
            end else if (lim > CW'(1) && swapped) begin
              lim     <= lim - CW'(1);
              ia      <= '0;
              ib      <= CW'(1);
              swapped <= 1'b0;
              state   <= S_RDA;
            end else if (c.op == pate_pkg::OP_DEDUP) begin
              ia    <= CW'(1);
              wr    <= CW'(1);
              state <= S_DDB;
            end else begin
              state <= S_FIN;
            end
          end
        end

        // Rotation runs three reversals; a plain reversal is the last one.
        S_NEXT: begin
          if (phase == 2'd0) begin
            phase <= 2'd1;
            ia    <= rk;
            ib    <= count - CW'(1);
            state <= S_SPAN;
          end else if (phase == 2'd1) begin
            phase <= 2'd2;
            ia    <= '0;
            ib    <= count - CW'(1);
            state <= S_SPAN;
          end else begin
            state <= S_FIN;
          end
        end

        // Entry 0 is always kept and seeds the comparison.
        S_DDB: begin
          last  <= rdata;
          state <= S_DEDUP;
        end

        // Compact sorted entries, keeping each new value once.
        S_DEDUP: begin
          if (keep_now) begin
            wr   <= wr + CW'(1);
            last <= rdata;
          end
          if (ia + CW'(1) < count) begin
            ia <= ia + CW'(1);
          end else begin
            count <= keep_now ? wr + CW'(1) : wr;
            state <= S_FIN;
          end
        end

        S_FIN: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // Response beat, held in registers until the next command.
  always_comb begin
    rsp.status       = status;
    rsp.result_value = rval;
    rsp.found_index  = 10'(fidx);
    rsp.count_after  = 11'(count);
  end

endmodule
